### rtl/ssu_pkg.sv
// shared types and constants for the sorted set engine
// no dependencies

package ssu_pkg;

    localparam int CAPACITY = 32;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ACT_W    = 3;
    localparam int STAT_W   = 2;
    localparam int COUNT_W  = 6;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD_A    = 3'd0,
        ACT_LOAD_B    = 3'd1,
        ACT_UNION     = 3'd2,
        ACT_INTERSECT = 3'd3,
        ACT_COMPARE   = 3'd4,
        ACT_READ_A    = 3'd5
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK             = 2'd0,
        ST_UNION_EXCEEDED = 2'd1,
        ST_LIST_FULL      = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_SORT_BEGIN,
        S_SORT_FIRST,
        S_SORT_STEP,
        S_SORT_END,
        S_COPY,
        S_INT_A,
        S_INT_HOLD,
        S_INT_B,
        S_CMP,
        S_OUT,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic               valid;
        logic [STAT_W-1:0]  status;
        logic               equal;
        logic [DATA_W-1:0]  element;
        logic               element_valid;
        logic [COUNT_W-1:0] count;
        logic               last_result;
    } result_t;

endpackage

### rtl/ssu_ram.sv
// generic single-write, single-read synchronous ram with registered read data
// no dependencies

module ssu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/ssu_seq.sv
// sequencer for the sorted set engine: walks one or both list memories per action
// depends on ssu_pkg

module ssu_seq (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [ssu_pkg::ACT_W-1:0]  action,
    input  logic [ssu_pkg::DATA_W-1:0] value,
    input  logic                       first,
    input  logic                       last,
    output ssu_pkg::mem_req_t          req_a,
    output ssu_pkg::mem_req_t          req_b,
    input  logic [ssu_pkg::DATA_W-1:0] rdata_a,
    input  logic [ssu_pkg::DATA_W-1:0] rdata_b,
    input  logic                       res_free,
    output ssu_pkg::result_t           res
);
    import ssu_pkg::*;

    seq_state_t state_reg, state_next;
    logic [ACT_W-1:0]  act_reg, act_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic              first_reg, first_next;
    logic              last_reg, last_next;
    logic              sel_b_reg, sel_b_next;
    logic [CNT_W-1:0]  cnt_a_reg, cnt_a_next;
    logic [CNT_W-1:0]  cnt_b_reg, cnt_b_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [CNT_W-1:0]  kept_reg, kept_next;
    logic [CNT_W-1:0]  pass_reg, pass_next;
    logic [DATA_W-1:0] hold_reg, hold_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic              eq_reg, eq_next;

    logic [CNT_W-1:0]   n_sort;
    logic [DATA_W-1:0]  s_rdata;
    logic [CNT_W-1:0]   n_load;
    logic [CNT_W:0]     union_sum;
    logic [CNT_W-1:0]   copy_addr;
    logic [CNT_W+COUNT_W-1:0] count_ext;
    mem_req_t           s_req;

    assign n_sort    = sel_b_reg ? cnt_b_reg : cnt_a_reg;
    assign s_rdata   = sel_b_reg ? rdata_b : rdata_a;
    assign union_sum = {1'b0, cnt_a_reg} + {1'b0, cnt_b_reg};
    assign copy_addr = cnt_a_reg + j_reg;
    assign count_ext = {{COUNT_W{1'b0}}, cnt_a_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_a_reg <= cnt_a_next;
            cnt_b_reg <= cnt_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        val_reg    <= val_next;
        first_reg  <= first_next;
        last_reg   <= last_next;
        sel_b_reg  <= sel_b_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        kept_reg   <= kept_next;
        pass_reg   <= pass_next;
        hold_reg   <= hold_next;
        status_reg <= status_next;
        eq_reg     <= eq_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        act_next    = act_reg;
        val_next    = val_reg;
        first_next  = first_reg;
        last_next   = last_reg;
        sel_b_next  = sel_b_reg;
        cnt_a_next  = cnt_a_reg;
        cnt_b_next  = cnt_b_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        kept_next   = kept_reg;
        pass_next   = pass_reg;
        hold_next   = hold_reg;
        status_next = status_reg;
        eq_next     = eq_reg;
        in_stall    = 1'b1;
        req_a       = '0;
        req_b       = '0;
        s_req       = '0;
        res         = '0;
        res.count   = count_ext[COUNT_W-1:0];
        n_load      = first_reg ? '0 : (sel_b_reg ? cnt_b_reg : cnt_a_reg);

        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    act_next    = action;
                    val_next    = value;
                    first_next  = first;
                    last_next   = last;
                    sel_b_next  = (action_t'(action) == ACT_LOAD_B);
                    status_next = ST_OK;
                    eq_next     = 1'b0;
                    state_next  = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_DONE;
                case (action_t'(act_reg))
                    ACT_LOAD_A, ACT_LOAD_B:
                    begin
                        if (n_load < CAP_CNT)
                        begin
                            s_req.we    = 1'b1;
                            s_req.waddr = n_load[ADDR_W-1:0];
                            s_req.wdata = val_reg;
                            if (sel_b_reg)
                                cnt_b_next = n_load + CNT_W'(1);
                            else
                                cnt_a_next = n_load + CNT_W'(1);
                        end
                        else
                        begin
                            status_next = ST_LIST_FULL;
                            if (sel_b_reg)
                                cnt_b_next = n_load;
                            else
                                cnt_a_next = n_load;
                        end
                        if (last_reg)
                            state_next = S_SORT_BEGIN;
                    end
                    ACT_UNION:
                    begin
                        if (union_sum > {1'b0, CAP_CNT})
                            status_next = ST_UNION_EXCEEDED;
                        else if (cnt_b_reg == '0)
                            state_next = S_SORT_BEGIN;
                        else
                        begin
                            req_b.re    = 1'b1;
                            req_b.raddr = '0;
                            j_next      = '0;
                            state_next  = S_COPY;
                        end
                    end
                    ACT_INTERSECT:
                    begin
                        if (cnt_a_reg == '0 || cnt_b_reg == '0)
                            cnt_a_next = '0;
                        else
                        begin
                            i_next     = '0;
                            kept_next  = '0;
                            state_next = S_INT_A;
                        end
                    end
                    ACT_COMPARE:
                    begin
                        if (cnt_a_reg != cnt_b_reg)
                            eq_next = 1'b0;
                        else if (cnt_a_reg == '0)
                            eq_next = 1'b1;
                        else
                        begin
                            req_a.re    = 1'b1;
                            req_a.raddr = '0;
                            req_b.re    = 1'b1;
                            req_b.raddr = '0;
                            i_next      = '0;
                            state_next  = S_CMP;
                        end
                    end
                    ACT_READ_A:
                    begin
                        if (cnt_a_reg != '0)
                        begin
                            req_a.re    = 1'b1;
                            req_a.raddr = '0;
                            i_next      = '0;
                            state_next  = S_OUT;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            // one bubble pass carries the running maximum in hold_reg
            S_SORT_BEGIN:
            begin
                if (n_sort < CNT_W'(2))
                    state_next = S_DONE;
                else
                begin
                    pass_next   = '0;
                    s_req.re    = 1'b1;
                    s_req.raddr = '0;
                    state_next  = S_SORT_FIRST;
                end
            end

            S_SORT_FIRST:
            begin
                hold_next   = s_rdata;
                s_req.re    = 1'b1;
                s_req.raddr = ADDR_W'(1);
                j_next      = CNT_W'(1);
                state_next  = S_SORT_STEP;
            end

            S_SORT_STEP:
            begin
                s_req.we    = 1'b1;
                s_req.waddr = j_reg[ADDR_W-1:0] - ADDR_W'(1);
                if ($signed(hold_reg) > $signed(s_rdata))
                    s_req.wdata = s_rdata;
                else
                begin
                    s_req.wdata = hold_reg;
                    hold_next   = s_rdata;
                end
                if (j_reg + CNT_W'(1) < n_sort)
                begin
                    s_req.re    = 1'b1;
                    s_req.raddr = j_reg[ADDR_W-1:0] + ADDR_W'(1);
                    j_next      = j_reg + CNT_W'(1);
                end
                else
                    state_next = S_SORT_END;
            end

            S_SORT_END:
            begin
                s_req.we    = 1'b1;
                s_req.waddr = j_reg[ADDR_W-1:0];
                s_req.wdata = hold_reg;
                pass_next   = pass_reg + CNT_W'(1);
                if (pass_reg + CNT_W'(2) < n_sort)
                begin
                    s_req.re    = 1'b1;
                    s_req.raddr = '0;
                    state_next  = S_SORT_FIRST;
                end
                else
                    state_next = S_DONE;
            end

            S_COPY:
            begin
                req_a.we    = 1'b1;
                req_a.waddr = copy_addr[ADDR_W-1:0];
                req_a.wdata = rdata_b;
                if (j_reg + CNT_W'(1) < cnt_b_reg)
                begin
                    req_b.re    = 1'b1;
                    req_b.raddr = j_reg[ADDR_W-1:0] + ADDR_W'(1);
                    j_next      = j_reg + CNT_W'(1);
                end
                else
                begin
                    cnt_a_next = union_sum[CNT_W-1:0];
                    sel_b_next = 1'b0;
                    state_next = S_SORT_BEGIN;
                end
            end

            S_INT_A:
            begin
                req_a.re    = 1'b1;
                req_a.raddr = i_reg[ADDR_W-1:0];
                state_next  = S_INT_HOLD;
            end

            S_INT_HOLD:
            begin
                hold_next   = rdata_a;
                req_b.re    = 1'b1;
                req_b.raddr = '0;
                j_next      = '0;
                state_next  = S_INT_B;
            end

            // kept never passes i, so the compaction write cannot hit an unread entry
            S_INT_B:
            begin
                if (rdata_b == hold_reg || j_reg + CNT_W'(1) >= cnt_b_reg)
                begin
                    if (rdata_b == hold_reg)
                    begin
                        req_a.we    = 1'b1;
                        req_a.waddr = kept_reg[ADDR_W-1:0];
                        req_a.wdata = hold_reg;
                        kept_next   = kept_reg + CNT_W'(1);
                    end
                    if (i_reg + CNT_W'(1) < cnt_a_reg)
                    begin
                        i_next     = i_reg + CNT_W'(1);
                        state_next = S_INT_A;
                    end
                    else
                    begin
                        cnt_a_next = kept_next;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    req_b.re    = 1'b1;
                    req_b.raddr = j_reg[ADDR_W-1:0] + ADDR_W'(1);
                    j_next      = j_reg + CNT_W'(1);
                end
            end

            S_CMP:
            begin
                if (rdata_a != rdata_b)
                begin
                    eq_next    = 1'b0;
                    state_next = S_DONE;
                end
                else if (i_reg + CNT_W'(1) < cnt_a_reg)
                begin
                    req_a.re    = 1'b1;
                    req_a.raddr = i_reg[ADDR_W-1:0] + ADDR_W'(1);
                    req_b.re    = 1'b1;
                    req_b.raddr = i_reg[ADDR_W-1:0] + ADDR_W'(1);
                    i_next      = i_reg + CNT_W'(1);
                end
                else
                begin
                    eq_next    = 1'b1;
                    state_next = S_DONE;
                end
            end

            // read data holds until the next read, so a stalled push just waits
            S_OUT:
            begin
                if (res_free)
                begin
                    res.valid         = 1'b1;
                    res.element       = rdata_a;
                    res.element_valid = 1'b1;
                    if (i_reg + CNT_W'(1) < cnt_a_reg)
                    begin
                        req_a.re    = 1'b1;
                        req_a.raddr = i_reg[ADDR_W-1:0] + ADDR_W'(1);
                        i_next      = i_reg + CNT_W'(1);
                    end
                    else
                    begin
                        res.last_result = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
            end

            S_DONE:
            begin
                if (res_free)
                begin
                    res.valid       = 1'b1;
                    res.status      = status_reg;
                    res.equal       = eq_reg;
                    res.last_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (state_reg == S_SORT_BEGIN || state_reg == S_SORT_FIRST ||
            state_reg == S_SORT_STEP || state_reg == S_SORT_END ||
            state_reg == S_EXEC)
        begin
            if (s_req.we || s_req.re)
            begin
                if (sel_b_reg)
                    req_b = s_req;
                else
                    req_a = s_req;
            end
        end
    end

`ifndef SYNTH
    a_cnt_a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_a_reg <= CAP_CNT)
        else $error("count of list a beyond capacity");

    a_cnt_b_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_b_reg <= CAP_CNT)
        else $error("count of list b beyond capacity");

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> res_free)
        else $error("result pushed into a full output register");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (req_a.we && req_a.re) |-> (req_a.waddr != req_a.raddr))
        else $error("read and write of the same entry of list a");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!req_a.we && !req_b.we))
        else $error("list memory written while idle");
`endif

endmodule

### rtl/sorted_set_engine.sv
// a load sorts its list after the last value; union copies B at one entry a cycle then sorts;
// intersection scans B for each entry of A; compare walks both lists in step; read-out gives
// one transaction a cycle when not stalled
// throughput: one transaction at a time, bounded by the single read port of each list ram
// reset: counts of both lists cleared, list contents undefined until written
// depends on ssu_pkg, ssu_ram and ssu_seq

module sorted_set_engine (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [ssu_pkg::ACT_W-1:0]   action,
    input  logic [ssu_pkg::DATA_W-1:0]  value,
    input  logic                        first,
    input  logic                        last,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [ssu_pkg::STAT_W-1:0]  status,
    output logic                        equal,
    output logic [ssu_pkg::DATA_W-1:0]  element,
    output logic                        element_valid,
    output logic [ssu_pkg::COUNT_W-1:0] count,
    output logic                        last_result
);
    import ssu_pkg::*;

    mem_req_t          req_a;
    mem_req_t          req_b;
    logic [DATA_W-1:0] rdata_a;
    logic [DATA_W-1:0] rdata_b;
    result_t           res;
    logic              res_free;

    // output register parts the sequencer from a stalled consumer
    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg, out_data_next;

    // list a: one write and one read per cycle
    ssu_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram_a (
        .clk   (clk),
        .we    (req_a.we),
        .waddr (req_a.waddr),
        .wdata (req_a.wdata),
        .re    (req_a.re),
        .raddr (req_a.raddr),
        .rdata (rdata_a)
    );

    // list b
    ssu_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram_b (
        .clk   (clk),
        .we    (req_b.we),
        .waddr (req_b.waddr),
        .wdata (req_b.wdata),
        .re    (req_b.re),
        .raddr (req_b.raddr),
        .rdata (rdata_b)
    );

    // sequencer: counts, sort passes, copy, intersection and compare walks
    ssu_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .action   (action),
        .value    (value),
        .first    (first),
        .last     (last),
        .req_a    (req_a),
        .req_b    (req_b),
        .rdata_a  (rdata_a),
        .rdata_b  (rdata_b),
        .res_free (res_free),
        .res      (res)
    );

    // slot is free when empty or emptied by this cycle's transaction
    assign res_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res.valid)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_data_reg.status;
    assign equal         = out_data_reg.equal;
    assign element       = out_data_reg.element;
    assign element_valid = out_data_reg.element_valid;
    assign count         = out_data_reg.count;
    assign last_result   = out_data_reg.last_result;

endmodule
